FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/abp_pkg.sv
package abp_pkg;

    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int OUT_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } abp_state_t;

    // Control handed from the sequencer to every cell of the ring.
    typedef struct packed {
        logic shift;
        logic insert;
    } ring_ctl_t;

endpackage

FILE: rtl/core/aabb_broad_phase_pairs.sv
// Channel  Dir  tdata (lowest bit up)                 tlast        tuser
// s_*      in   min_x, min_y, max_x, max_y            -            start_of_frame
// m_*      out  earlier_index, new_index, zero pad    last_of_run  overflow_seen
//
// Every accepted box is taken in the idle state; then the stored boxes, held in a
// ring of cells, turn once past the head cell, which is tested against the new box
// at each step, and the flush state releases the last pair of the run. The scan and
// the flush can be held while the result beat is stalled. A box that finds the store
// full is taken without a scan.
// Reset clears the box count, the overflow flag, the pending-pair flag and the handshake state only.
module aabb_broad_phase_pairs #(
    parameter int MAX_BODIES = 64,
    parameter int COORD_BITS = 20,
    localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_W-1:0]             s_tdata,   // min_x, min_y, max_x, max_y, zero pad
    input  logic                        s_tuser,   // start_of_frame
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [abp_pkg::OUT_W-1:0]   m_tdata,   // earlier_index, new_index, zero pad
    output logic                        m_tlast,
    output logic                        m_tuser    // overflow_seen
);
    import abp_pkg::*;

    localparam int BOX_W = 4 * COORD_BITS;

    ring_ctl_t        ctl;
    logic [BOX_W-1:0] ins_box;
    logic [BOX_W-1:0] ring [MAX_BODIES];

    abp_ctrl #(
        .MAX_BODIES (MAX_BODIES),
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .head_box (ring[0]),
        .ins_box  (ins_box),
        .ctl      (ctl)
    );

    // Each cell takes the box of the cell after it; the tail takes the head.
    for (genvar i = 0; i < MAX_BODIES; i++)
    begin : g_cell
        abp_cell #(
            .COORD_BITS (COORD_BITS),
            .IS_TAIL    (i == MAX_BODIES - 1)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .nxt_box (ring[(i + 1) % MAX_BODIES]),
            .ins_box (ins_box),
            .box     (ring[i])
        );
    end

endmodule

FILE: rtl/core/abp_cell.sv
module abp_cell #(
    parameter int COORD_BITS = 20,
    parameter bit IS_TAIL    = 1'b0
) (
    input  logic                      clk,
    input  abp_pkg::ring_ctl_t        ctl,
    input  logic [4*COORD_BITS-1:0]   nxt_box,
    input  logic [4*COORD_BITS-1:0]   ins_box,
    output logic [4*COORD_BITS-1:0]   box
);
    import abp_pkg::*;

    logic [4*COORD_BITS-1:0] box_reg;
    logic [4*COORD_BITS-1:0] box_next;

    // The tail closes the ring and is where a new box joins it.
    always_comb
    begin
        box_next = box_reg;
        if (ctl.shift)
        begin
            if (IS_TAIL && ctl.insert)
            begin
                box_next = ins_box;
            end
            else
            begin
                box_next = nxt_box;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    assign box = box_reg;

endmodule

FILE: rtl/core/abp_ctrl.sv
module abp_ctrl #(
    parameter int MAX_BODIES = 64,
    parameter int COORD_BITS = 20,
    parameter int IN_W       = 80
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_W-1:0]             s_tdata,
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [abp_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser,
    input  logic [4*COORD_BITS-1:0]     head_box,
    output logic [4*COORD_BITS-1:0]     ins_box,
    output abp_pkg::ring_ctl_t          ctl
);
    import abp_pkg::*;

    localparam int CB = COORD_BITS;

    abp_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg;
    logic                    ovf_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic [4*CB-1:0]         query_reg;
    logic                    pend_valid_reg;
    logic [IDX_W-1:0]        pend_idx_reg;
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_earlier_reg;
    logic [IDX_W-1:0]        out_new_reg;
    logic                    out_last_reg;
    logic                    out_ovf_reg;

    logic                    accept;
    logic [CNT_W-1:0]        eff_count;
    logic                    eff_ovf;
    logic                    full;
    logic                    touch;
    logic                    hit;
    logic                    out_free;
    logic                    step;
    logic                    scan_end;
    logic                    out_load;
    logic                    out_last;

    assign accept    = s_tvalid && s_tready;
    assign eff_count = s_tuser ? '0 : count_reg;
    assign eff_ovf   = s_tuser ? 1'b0 : ovf_reg;
    assign full      = eff_count >= CNT_W'(MAX_BODIES);
    assign out_free  = !out_valid_reg || m_tready;
    assign scan_end  = pos_reg == IDX_W'(MAX_BODIES - 1);

    // Inclusive overlap of the query box and the stored box at the ring head.
    assign touch =
        ($signed(query_reg[CB-1:0])      <= $signed(head_box[3*CB-1:2*CB])) &&
        ($signed(head_box[CB-1:0])       <= $signed(query_reg[3*CB-1:2*CB])) &&
        ($signed(query_reg[2*CB-1:CB])   <= $signed(head_box[4*CB-1:3*CB])) &&
        ($signed(head_box[2*CB-1:CB])    <= $signed(query_reg[4*CB-1:3*CB]));

    assign hit = (state_reg == ST_SCAN) && (pos_reg < slot_reg) && touch;

    // A pair is held back until the next hit or the end of the scan shows
    // whether it closes the run.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !full)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step && scan_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        step       = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        ctl.shift  = 1'b0;
        ctl.insert = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SCAN:
            begin
                step       = !(hit && pend_valid_reg && !out_free);
                out_load   = hit && pend_valid_reg && out_free;
                ctl.shift  = step;
                ctl.insert = pos_reg == slot_reg;
            end
            ST_FLUSH:
            begin
                out_load = pend_valid_reg && out_free;
                out_last = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (full)
                begin
                    count_reg <= eff_count;
                    ovf_reg   <= 1'b1;
                end
                else
                begin
                    count_reg <= eff_count + CNT_W'(1);
                    ovf_reg   <= eff_ovf;
                end
            end
            if (hit && step)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_FLUSH && out_load)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg  <= eff_count[IDX_W-1:0];
            pos_reg   <= '0;
            query_reg <= s_tdata[4*CB-1:0];
        end
        else if (step)
        begin
            pos_reg <= pos_reg + IDX_W'(1);
        end
        if (hit && step)
        begin
            pend_idx_reg <= pos_reg;
        end
        if (out_load)
        begin
            out_earlier_reg <= pend_idx_reg;
            out_new_reg     <= slot_reg;
            out_last_reg    <= out_last;
            out_ovf_reg     <= ovf_reg;
        end
    end

    assign ins_box  = query_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - 2 * IDX_W)'(0), out_new_reg, out_earlier_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

FILE: rtl/core/abp_checker.sv
`include "assert_macros.svh"

module abp_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [abp_pkg::OUT_W-1:0]   m_tdata
);
    import abp_pkg::*;

    // A result beat that is not taken stays offered.
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat withdrawn")

    // The stored box always carries the lower frame index.
    `ASSERT_IMPL(a_idx_order, m_tvalid, m_tdata[IDX_W-1:0] < m_tdata[2*IDX_W-1:IDX_W],
        "earlier index not below new index")

    // A box that opens a frame always finds room and starts a scan.
    `ASSERT_NEXT(a_sof_scan, s_tvalid && s_tready && s_tuser, !s_tready,
        "start of frame box not scanned")

endmodule

bind aabb_broad_phase_pairs abp_checker u_abp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/tb_aabb_broad_phase_pairs.sv
module tb_aabb_broad_phase_pairs;

    localparam int NBODIES    = 64;
    localparam int CW         = 20;
    localparam int IN_BITS    = ((4 * CW + 7) / 8) * 8;
    localparam int QUIET_MAX  = 20000;
    localparam int HOLD_AT    = 40;
    localparam int HOLD_LEN   = 700;
    localparam int REPORT_MAX = 40;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic [5:0] earlier_idx;
        logic [5:0] new_idx;
        logic       last_pair;
        logic       ovf;
    } pair_t;

    // Tracks the boxes of the current frame and the pairs they must produce.
    class pair_board;
        coord_t      lo_x [NBODIES];
        coord_t      hi_x [NBODIES];
        coord_t      lo_y [NBODIES];
        coord_t      hi_y [NBODIES];
        int unsigned stored;
        bit          dropped;
        pair_t       owed [$];
        int          errors;

        function new();
            stored  = 0;
            dropped = 0;
            errors  = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= REPORT_MAX)
                $display("ERROR: %s", msg);
        endtask

        function void note_box(input bit sof, input coord_t x0, input coord_t y0,
                               input coord_t x1, input coord_t y1);
            pair_t p;
            int    hits;
            if (sof)
            begin
                stored  = 0;
                dropped = 0;
            end
            if (stored >= NBODIES)
            begin
                dropped = 1;
                return;
            end
            hits = 0;
            for (int unsigned k = 0; k < stored; k++)
            begin
                if (x0 <= hi_x[k] && lo_x[k] <= x1 && y0 <= hi_y[k] && lo_y[k] <= y1)
                begin
                    p.earlier_idx = 6'(k);
                    p.new_idx     = 6'(stored);
                    p.last_pair   = 1'b0;
                    p.ovf         = dropped;
                    owed = {owed, p};
                    hits++;
                end
            end
            if (hits > 0)
                owed[owed.size() - 1].last_pair = 1'b1;
            lo_x[stored] = x0;
            hi_x[stored] = x1;
            lo_y[stored] = y0;
            hi_y[stored] = y1;
            stored++;
        endfunction

        task check_pair(input logic [15:0] data, input logic last, input logic user);
            pair_t want;
            if (owed.size() == 0)
            begin
                report($sformatf("pair %0d-%0d arrived with none expected",
                                 data[5:0], data[11:6]));
                return;
            end
            want = owed.pop_front();
            if (data[5:0] !== want.earlier_idx)
                report($sformatf("earlier_index %0d, expected %0d",
                                 data[5:0], want.earlier_idx));
            if (data[11:6] !== want.new_idx)
                report($sformatf("new_index %0d, expected %0d", data[11:6], want.new_idx));
            if (last !== want.last_pair)
                report($sformatf("last_of_run %b, expected %b on pair %0d-%0d",
                                 last, want.last_pair, want.earlier_idx, want.new_idx));
            if (user !== want.ovf)
                report($sformatf("overflow_seen %b, expected %b", user, want.ovf));
        endtask

        task drop_leftovers();
            if (owed.size() > 0)
                report($sformatf("%0d pair(s) never emitted", owed.size()));
            owed.delete();
        endtask
    endclass

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_BITS-1:0] s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    pair_board board;
    int        src_idle;
    int        snk_idle;
    int        boxes_sent;
    int        quiet_cycles;
    int        hold_left;
    bit        hold_done;

    aabb_broad_phase_pairs #(
        .MAX_BODIES (NBODIES),
        .COORD_BITS (CW)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_box(input bit sof, input int x0, input int y0,
                            input int x1, input int y1);
        coord_t cx0, cy0, cx1, cy1;
        cx0 = coord_t'(x0);
        cy0 = coord_t'(y0);
        cx1 = coord_t'(x1);
        cy1 = coord_t'(y1);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sof;
        s_tdata  <= {cy1, cx1, cy0, cx0};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_box(sof, cx0, cy0, cx1, cy1);
        boxes_sent++;
    endtask

    // Always lowers valid before waiting on the clock, so a following send never
    // reassigns it within the same step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.owed.size() > 0);
    endtask

    task automatic directed_boxes();
        send_box(1'b1, 0, 0, 10, 10);
        send_box(1'b0, 10, 10, 20, 20);       // meets the first box at one corner
        send_box(1'b0, 5, 5, 15, 15);
        send_box(1'b0, 21, 0, 30, 9);         // clear of everything by one unit
        send_box(1'b0, 8, 8, 2, 2);           // inverted on both axes
        send_box(1'b0, -524288, -524288, 524287, 524287);
        send_box(1'b0, 524287, 524287, 524287, 524287);
        send_box(1'b0, -524288, -524288, -524288, -524288);
        send_box(1'b0, 524287, -524288, -524288, 524287);
        send_box(1'b0, 20, -5, 25, 9);
        send_box(1'b1, -100, -100, -100, -100);
        send_box(1'b0, -100, -100, -100, -100);
        send_box(1'b0, -101, -101, -101, -101);
        send_box(1'b0, -524288, 524287, 524287, -524288);
    endtask

    // One frame of boxes scattered over a patch of the plane; dense enough that
    // most boxes hit several earlier ones.
    task automatic random_frame(input int boxes);
        int bx, by, spread, sel, ax, ay, bw, bh, top;
        int x0, y0, x1, y1;
        spread = (boxes > 16) ? 4096 : 768;
        top    = 1048575 - 2 * 4096 - 512;
        bx     = int'($urandom_range(0, top)) - 524288 + 256;
        by     = int'($urandom_range(0, top)) - 524288 + 256;
        sel    = int'($urandom_range(0, 7));
        if (sel == 0)
        begin
            bx = -524288 + 256;
            by = -524288 + 256;
        end
        else if (sel == 1)
        begin
            bx = top - 524288 + 256;
            by = top - 524288 + 256;
        end
        for (int i = 0; i < boxes; i++)
        begin
            sel = int'($urandom_range(0, 99));
            ax  = bx + int'($urandom_range(0, spread));
            ay  = by + int'($urandom_range(0, spread));
            bw  = int'($urandom_range(0, spread / 2));
            bh  = int'($urandom_range(0, spread / 2));
            if (sel < 80)
            begin
                x0 = ax;
                y0 = ay;
                x1 = ax + bw;
                y1 = ay + bh;
            end
            else if (sel < 90)
            begin
                x0 = ax;
                y0 = ay;
                x1 = ax - 1 - (bw % 200);
                y1 = (sel < 85) ? (ay + bh) : (ay - 1 - (bh % 200));
            end
            else
            begin
                x0 = int'($urandom_range(0, 1048575)) - 524288;
                y0 = int'($urandom_range(0, 1048575)) - 524288;
                x1 = int'($urandom_range(0, 1048575)) - 524288;
                y1 = int'($urandom_range(0, 1048575)) - 524288;
            end
            send_box(i == 0, x0, y0, x1, y1);
        end
    endtask

    // Result side: checks each beat and decides the next ready level.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_pair(m_tdata, m_tlast, m_tuser);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && boxes_sent >= HOLD_AT)
            begin
                hold_done = 1;
                hold_left = HOLD_LEN;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        wait (rst_n);
        while (quiet_cycles < QUIET_MAX)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL aabb_broad_phase_pairs");
        $finish;
    end

    initial
    begin
        int left, n;
        board      = new();
        src_idle   = 0;
        snk_idle   = 0;
        boxes_sent = 0;
        hold_left  = 0;
        hold_done  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_boxes();
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle = 29;
                    snk_idle = 82;
                end
                1:
                begin
                    src_idle = 82;
                    snk_idle = 29;
                end
                default:
                begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            left = (phase == 2) ? 98 : 99;
            // A frame longer than the store, so that the last boxes are dropped.
            if (phase != 1)
            begin
                random_frame(NBODIES + 4);
                left -= NBODIES + 4;
            end
            while (left > 0)
            begin
                n = $urandom_range(1, 12);
                if (n > left)
                    n = left;
                random_frame(n);
                left -= n;
            end
            wait_drained();
        end

        repeat (NBODIES + 16) @(posedge clk);
        board.drop_leftovers();
        if (board.errors == 0)
            $display("PASS aabb_broad_phase_pairs");
        else
            $display("FAIL aabb_broad_phase_pairs");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/abp_pkg.sv
rtl/core/abp_cell.sv
rtl/core/abp_ctrl.sv
rtl/core/aabb_broad_phase_pairs.sv
rtl/core/abp_checker.sv
verif/tb_aabb_broad_phase_pairs.sv
